>>> sv/greedy_box_suppression_core_macros.svh
// Assertion macros for the greedy box suppression core.
`ifndef GREEDY_BOX_SUPPRESSION_CORE_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_CORE_MACROS_SVH

// Checked only while out of reset.
`define GBS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("gbs assertion failed");

// Checked on every edge, reset included.
`define GBS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gbs assertion failed");

`endif

>>> sv/gbs_pkg.sv
`timescale 1ns / 1ps
package gbs_pkg;

    localparam int NUM_BOXES  = 64;
    localparam int IDX_W      = $clog2(NUM_BOXES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 16;
    localparam int BOX_W      = 4 * COORD_W;
    localparam int SCORE_W    = 16;
    localparam int THR_W      = 16;
    localparam int ETA_W      = 16;
    localparam int TOPK_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0] THR_HALF    = 16'd32768;
    localparam logic [ETA_W-1:0] ETA_ONE     = 16'd32768;
    localparam logic [THR_W-1:0] OVL_RESET   = 16'd29491;
    localparam logic [TOPK_W-1:0] TOPK_RESET = 8'hFF;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCORE_THR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OVL_THR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ETA       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOPK      = 2'd3;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RANK_I,
        ST_RANK_SI,
        ST_RANK_J,
        ST_RANK_CJ,
        ST_RANK_WR,
        ST_TOPK,
        ST_SUP_ORD,
        ST_SUP_BOX,
        ST_SUP_LATCH,
        ST_CMP_LIST,
        ST_CMP_BOX,
        ST_CMP_START,
        ST_CMP_WAIT,
        ST_KEEP,
        ST_EMIT_RD,
        ST_EMIT_SHOW,
        ST_EMIT_WAIT
    } gbs_state_t;

    typedef struct packed {
        logic             start;
        logic [BOX_W-1:0] box_a;
        logic [BOX_W-1:0] box_b;
        logic [THR_W-1:0] thr;
    } gbs_iou_req_t;

    typedef struct packed {
        logic done;
        logic keep_ok;
    } gbs_iou_rsp_t;

endpackage

>>> sv/gbs_ram.sv
`timescale 1ns / 1ps
module gbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/gbs_iou.sv
`timescale 1ns / 1ps
module gbs_iou (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gbs_pkg::gbs_iou_req_t req,
    output gbs_pkg::gbs_iou_rsp_t rsp
);
    import gbs_pkg::*;

    logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [COORD_W-1:0] lx, ly, hx, hy;
    logic signed [COORD_W:0]   dx, dy, aw, ah, bw, bh;

    logic [COORD_W-1:0] dx1_reg, dy1_reg, aw1_reg, ah1_reg, bw1_reg, bh1_reg;
    logic               ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    logic [THR_W-1:0]   thr1_reg, thr2_reg, thr3_reg;
    logic [31:0]        inter2_reg, area_a2_reg, area_b2_reg, inter3_reg;
    logic [33:0]        uni3_reg;
    logic [47:0]        lhs4_reg;
    logic [49:0]        prod4_reg;
    logic [3:0]         vld_reg;
    logic               done_reg, keep_ok_reg;

    always_comb begin
        ax0 = req.box_a[15:0];
        ay0 = req.box_a[31:16];
        ax1 = req.box_a[47:32];
        ay1 = req.box_a[63:48];
        bx0 = req.box_b[15:0];
        by0 = req.box_b[31:16];
        bx1 = req.box_b[47:32];
        by1 = req.box_b[63:48];
        lx  = (ax0 > bx0) ? ax0 : bx0;
        ly  = (ay0 > by0) ? ay0 : by0;
        hx  = (ax1 < bx1) ? ax1 : bx1;
        hy  = (ay1 < by1) ? ay1 : by1;
        dx  = 17'(hx) - 17'(lx);
        dy  = 17'(hy) - 17'(ly);
        aw  = 17'(ax1) - 17'(ax0);
        ah  = 17'(ay1) - 17'(ay0);
        bw  = 17'(bx1) - 17'(bx0);
        bh  = 17'(by1) - 17'(by0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            vld_reg  <= {vld_reg[2:0], req.start};
            done_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        // stage 1: overlap extents and box sides
        ok1_reg  <= (dx > 0) && (dy > 0);
        dx1_reg  <= dx[15:0];
        dy1_reg  <= dy[15:0];
        aw1_reg  <= (aw[16] || ah[16]) ? '0 : aw[15:0];
        ah1_reg  <= (aw[16] || ah[16]) ? '0 : ah[15:0];
        bw1_reg  <= (bw[16] || bh[16]) ? '0 : bw[15:0];
        bh1_reg  <= (bw[16] || bh[16]) ? '0 : bh[15:0];
        thr1_reg <= req.thr;
        // stage 2: products
        ok2_reg     <= ok1_reg;
        inter2_reg  <= ok1_reg ? dx1_reg * dy1_reg : '0;
        area_a2_reg <= aw1_reg * ah1_reg;
        area_b2_reg <= bw1_reg * bh1_reg;
        thr2_reg    <= thr1_reg;
        // stage 3: union
        ok3_reg    <= ok2_reg;
        uni3_reg   <= 34'(area_a2_reg) + 34'(area_b2_reg) - 34'(inter2_reg);
        inter3_reg <= inter2_reg;
        thr3_reg   <= thr2_reg;
        // stage 4: cross-multiplied terms
        ok4_reg   <= ok3_reg;
        lhs4_reg  <= {inter3_reg, 16'd0};
        prod4_reg <= thr3_reg * uni3_reg;
        // stage 5: compare
        keep_ok_reg <= !ok4_reg || (50'(lhs4_reg) <= prod4_reg);
    end

    assign rsp.done    = done_reg;
    assign rsp.keep_ok = keep_ok_reg;

endmodule

>>> sv/greedy_box_suppression_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | box corners, score, final_box
// m_      | out       | m_valid / m_ready  | kept_index, kept_valid, last_result
// cfg_    | in        | cfg_we             | cfg_addr, cfg_wdata
// Loading takes one box per cycle; final_box closes the set.
// Ranking compares scores over the single score memory port.
// Suppression compares each candidate with kept boxes (5-stage IoU pipeline).
// Each result is held until m_ready; s_ready is low until the last result
// leaves. Reset is synchronous; the memories need no clearing.
module greedy_box_suppression_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gbs_pkg::COORD_W-1:0]  s_box_xmin,
    input  logic signed [gbs_pkg::COORD_W-1:0]  s_box_ymin,
    input  logic signed [gbs_pkg::COORD_W-1:0]  s_box_xmax,
    input  logic signed [gbs_pkg::COORD_W-1:0]  s_box_ymax,
    input  logic [gbs_pkg::SCORE_W-1:0]         s_box_score,
    input  logic                                s_final_box,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gbs_pkg::IDX_W-1:0]           m_kept_index,
    output logic                                m_kept_valid,
    output logic                                m_last_result,
    input  logic                                cfg_we,
    input  logic [gbs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [gbs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import gbs_pkg::*;

    gbs_state_t state_reg, state_next;

    logic [SCORE_W-1:0] score_thr_reg;
    logic [THR_W-1:0]   ovl_thr_reg, live_thr_reg;
    logic [ETA_W-1:0]   eta_reg;
    logic [TOPK_W-1:0]  topk_reg;

    logic [CNT_W-1:0] loaded_count_reg, n_reg, m_reg, i_reg, j_reg, rank_reg;
    logic [CNT_W-1:0] kept_count_reg, k_reg, e_reg;
    logic [SCORE_W-1:0] si_reg;
    logic [IDX_W-1:0]   cand_reg;
    logic [BOX_W-1:0]   box_a_reg;
    logic               out_valid_reg, out_kvalid_reg, out_last_reg;
    logic [IDX_W-1:0]   out_idx_reg;

    logic s_acc, store_ok, rank_hit, i_last, j_last, k_last, last_emit;
    logic [CNT_W-1:0] m_eff;
    logic [31:0] decay;

    logic               box_we, box_re, score_re, ord_we, ord_re, kept_we, kept_re;
    logic [IDX_W-1:0]   box_raddr, score_raddr, ord_raddr, kept_raddr;
    logic [BOX_W-1:0]   box_rdata;
    logic [SCORE_W-1:0] score_rdata;
    logic [IDX_W-1:0]   ord_rdata, kept_rdata;

    gbs_iou_req_t iou_req;
    gbs_iou_rsp_t iou_rsp;

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_acc    = s_valid && s_ready;
    assign store_ok = !loaded_count_reg[CNT_W-1];
    assign rank_hit = (score_rdata > si_reg) ||
                      ((score_rdata == si_reg) && (j_reg < i_reg));
    assign i_last   = (i_reg + 1'b1) == n_reg;
    assign j_last   = (j_reg + 1'b1) == n_reg;
    assign k_last   = (k_reg + 1'b1) == kept_count_reg;
    assign last_emit = (e_reg + 1'b1) == kept_count_reg;
    assign decay    = live_thr_reg * eta_reg;

    always_comb begin
        m_eff = m_reg;
        if (!topk_reg[TOPK_W-1] && ({1'b0, topk_reg[TOPK_W-2:0]} < 8'(m_reg))) begin
            m_eff = topk_reg[CNT_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:      if (s_acc && s_final_box) state_next = ST_RANK_I;
            ST_RANK_I:    state_next = ST_RANK_SI;
            ST_RANK_SI: begin
                if (score_rdata > score_thr_reg) state_next = ST_RANK_J;
                else if (i_last) state_next = ST_TOPK;
                else state_next = ST_RANK_I;
            end
            ST_RANK_J:    state_next = ST_RANK_CJ;
            ST_RANK_CJ:   state_next = j_last ? ST_RANK_WR : ST_RANK_J;
            ST_RANK_WR:   state_next = i_last ? ST_TOPK : ST_RANK_I;
            ST_TOPK:      state_next = (m_eff == '0) ? ST_EMIT_RD : ST_SUP_ORD;
            ST_SUP_ORD:   state_next = ST_SUP_BOX;
            ST_SUP_BOX:   state_next = ST_SUP_LATCH;
            ST_SUP_LATCH: state_next = (kept_count_reg == '0) ? ST_KEEP : ST_CMP_LIST;
            ST_CMP_LIST:  state_next = ST_CMP_BOX;
            ST_CMP_BOX:   state_next = ST_CMP_START;
            ST_CMP_START: state_next = ST_CMP_WAIT;
            ST_CMP_WAIT: begin
                if (iou_rsp.done) begin
                    if (!iou_rsp.keep_ok) begin
                        state_next = ((i_reg + 1'b1) == m_reg) ? ST_EMIT_RD : ST_SUP_ORD;
                    end else if (k_last) begin
                        state_next = ST_KEEP;
                    end else begin
                        state_next = ST_CMP_LIST;
                    end
                end
            end
            ST_KEEP:      state_next = ((i_reg + 1'b1) == m_reg) ? ST_EMIT_RD : ST_SUP_ORD;
            ST_EMIT_RD:   state_next = (kept_count_reg == '0) ? ST_EMIT_WAIT : ST_EMIT_SHOW;
            ST_EMIT_SHOW: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (m_ready) state_next = out_last_reg ? ST_LOAD : ST_EMIT_RD;
            end
            default:      state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        box_we      = 1'b0;
        box_re      = 1'b0;
        box_raddr   = ord_rdata;
        score_re    = 1'b0;
        score_raddr = i_reg[IDX_W-1:0];
        ord_we      = 1'b0;
        ord_re      = 1'b0;
        ord_raddr   = i_reg[IDX_W-1:0];
        kept_we     = 1'b0;
        kept_re     = 1'b0;
        kept_raddr  = k_reg[IDX_W-1:0];
        case (state_reg)
            ST_LOAD:     box_we = s_acc && store_ok;
            ST_RANK_I:   score_re = 1'b1;
            ST_RANK_J: begin
                score_re    = 1'b1;
                score_raddr = j_reg[IDX_W-1:0];
            end
            ST_RANK_WR:  ord_we = 1'b1;
            ST_SUP_ORD:  ord_re = 1'b1;
            ST_SUP_BOX:  box_re = 1'b1;
            ST_CMP_LIST: kept_re = 1'b1;
            ST_CMP_BOX: begin
                box_re    = 1'b1;
                box_raddr = kept_rdata;
            end
            ST_KEEP:     kept_we = 1'b1;
            ST_EMIT_RD: begin
                kept_re    = 1'b1;
                kept_raddr = e_reg[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_thr_reg <= '0;
            ovl_thr_reg   <= OVL_RESET;
            eta_reg       <= ETA_ONE;
            topk_reg      <= TOPK_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_SCORE_THR: score_thr_reg <= cfg_wdata;
                CFG_OVL_THR:   ovl_thr_reg   <= cfg_wdata;
                CFG_ETA:       eta_reg       <= cfg_wdata;
                CFG_TOPK:      topk_reg      <= cfg_wdata[TOPK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_count_reg <= '0;
            kept_count_reg   <= '0;
            live_thr_reg     <= '0;
            out_valid_reg    <= 1'b0;
            i_reg            <= '0;
            m_reg            <= '0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_acc) begin
                        if (s_final_box) begin
                            loaded_count_reg <= '0;
                            n_reg <= store_ok ? loaded_count_reg + 1'b1 : loaded_count_reg;
                            i_reg <= '0;
                            m_reg <= '0;
                        end else if (store_ok) begin
                            loaded_count_reg <= loaded_count_reg + 1'b1;
                        end
                    end
                end
                ST_RANK_SI: begin
                    si_reg   <= score_rdata;
                    j_reg    <= '0;
                    rank_reg <= '0;
                    if (score_rdata <= score_thr_reg) i_reg <= i_reg + 1'b1;
                end
                ST_RANK_CJ: begin
                    if (rank_hit) rank_reg <= rank_reg + 1'b1;
                    j_reg <= j_reg + 1'b1;
                end
                ST_RANK_WR: begin
                    m_reg <= m_reg + 1'b1;
                    i_reg <= i_reg + 1'b1;
                end
                ST_TOPK: begin
                    m_reg          <= m_eff;
                    i_reg          <= '0;
                    kept_count_reg <= '0;
                    live_thr_reg   <= ovl_thr_reg;
                    e_reg          <= '0;
                end
                ST_SUP_BOX:   cand_reg <= ord_rdata;
                ST_SUP_LATCH: begin
                    box_a_reg <= box_rdata;
                    k_reg     <= '0;
                end
                ST_CMP_WAIT: begin
                    if (iou_rsp.done) begin
                        if (!iou_rsp.keep_ok) i_reg <= i_reg + 1'b1;
                        else k_reg <= k_reg + 1'b1;
                    end
                end
                ST_KEEP: begin
                    kept_count_reg <= kept_count_reg + 1'b1;
                    i_reg          <= i_reg + 1'b1;
                    if ((eta_reg < ETA_ONE) && (live_thr_reg > THR_HALF)) begin
                        live_thr_reg <= decay[30:15];
                    end
                end
                ST_EMIT_RD: begin
                    if (kept_count_reg == '0) begin
                        out_idx_reg    <= '0;
                        out_kvalid_reg <= 1'b0;
                        out_last_reg   <= 1'b1;
                        out_valid_reg  <= 1'b1;
                    end
                end
                ST_EMIT_SHOW: begin
                    out_idx_reg    <= kept_rdata;
                    out_kvalid_reg <= 1'b1;
                    out_last_reg   <= last_emit;
                    out_valid_reg  <= 1'b1;
                end
                ST_EMIT_WAIT: begin
                    if (m_ready) begin
                        out_valid_reg <= 1'b0;
                        e_reg         <= e_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign iou_req.start = (state_reg == ST_CMP_START);
    assign iou_req.box_a = box_a_reg;
    assign iou_req.box_b = box_rdata;
    assign iou_req.thr   = live_thr_reg;

    gbs_ram #(.WIDTH(BOX_W), .DEPTH(NUM_BOXES)) u_box_ram (
        .aclk  (aclk),
        .we    (box_we),
        .waddr (loaded_count_reg[IDX_W-1:0]),
        .wdata ({s_box_ymax, s_box_xmax, s_box_ymin, s_box_xmin}),
        .re    (box_re),
        .raddr (box_raddr),
        .rdata (box_rdata)
    );

    gbs_ram #(.WIDTH(SCORE_W), .DEPTH(NUM_BOXES)) u_score_ram (
        .aclk  (aclk),
        .we    (box_we),
        .waddr (loaded_count_reg[IDX_W-1:0]),
        .wdata (s_box_score),
        .re    (score_re),
        .raddr (score_raddr),
        .rdata (score_rdata)
    );

    gbs_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BOXES)) u_order_ram (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (rank_reg[IDX_W-1:0]),
        .wdata (i_reg[IDX_W-1:0]),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    gbs_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BOXES)) u_kept_ram (
        .aclk  (aclk),
        .we    (kept_we),
        .waddr (kept_count_reg[IDX_W-1:0]),
        .wdata (cand_reg),
        .re    (kept_re),
        .raddr (kept_raddr),
        .rdata (kept_rdata)
    );

    gbs_iou u_iou (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iou_req),
        .rsp     (iou_rsp)
    );

    assign m_valid       = out_valid_reg;
    assign m_kept_index  = out_idx_reg;
    assign m_kept_valid  = out_kvalid_reg;
    assign m_last_result = out_last_reg;

endmodule

>>> sv/gbs_checker.sv
`timescale 1ns / 1ps
`include "greedy_box_suppression_core_macros.svh"
module gbs_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [gbs_pkg::COORD_W-1:0]        s_box_xmin,
    input logic [gbs_pkg::COORD_W-1:0]        s_box_ymin,
    input logic [gbs_pkg::COORD_W-1:0]        s_box_xmax,
    input logic [gbs_pkg::COORD_W-1:0]        s_box_ymax,
    input logic [gbs_pkg::SCORE_W-1:0]        s_box_score,
    input logic                               s_final_box,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [gbs_pkg::IDX_W-1:0]          m_kept_index,
    input logic                               m_kept_valid,
    input logic                               m_last_result,
    input logic                               cfg_we,
    input logic [gbs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input logic [gbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    `GBS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)
    `GBS_ASSERT(a_no_load_while_out, aclk, aresetn, !(s_ready && m_valid))
    `GBS_ASSERT(a_empty_is_last, aclk, aresetn, (m_valid && !m_kept_valid) |-> m_last_result)
    `GBS_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_kept_index)))

endmodule

bind greedy_box_suppression_core gbs_checker u_gbs_checker (.*);
